// File: design/clcd_pkg.sv
// Shared types and constants for the CR LF line LED command decoder.
// No dependencies; imported by every design file.
package clcd_pkg;

    localparam int unsigned LINE_MAX   = 256;
    localparam int unsigned HEAD_DEPTH = 8;
    localparam int unsigned CNT_W      = 14;
    localparam int unsigned HEAD_IDX_W = 3;

    localparam logic [7:0] BYTE_CR   = 8'h0d;
    localparam logic [7:0] BYTE_LF   = 8'h0a;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_L      = 8'h6c;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_M      = 8'h6d;
    localparam logic [7:0] CH_O      = 8'h6f;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_EIGHT  = 8'h38;

    typedef enum logic [1:0] {
        EV_TAKEN    = 2'd0,
        EV_LINE     = 2'd1,
        EV_DROP_LF  = 2'd2,
        EV_DROP_OVF = 2'd3
    } line_event_t;

    typedef logic [7:0] head_t [HEAD_DEPTH];

    // Header decode outcome
    typedef struct packed {
        logic       hit;
        logic [7:0] led_new;
    } decode_t;

    // One result word
    typedef struct packed {
        line_event_t line_event;
        logic [7:0]  led_mask;
        logic        command_hit;
    } result_t;

endpackage

// File: design/clcd_decode.sv
// Combinational header decode: #ledNon, #ledNoff, #cmd1, #cmd2.
// Depends on clcd_pkg.
module clcd_decode (
    input  clcd_pkg::head_t   head,
    input  logic [7:0]        led_cur,
    output clcd_pkg::decode_t dec
);
    import clcd_pkg::*;

    logic       valid_n;
    logic [2:0] n_idx;
    logic [7:0] bit_sel;
    logic [7:0] n_off;

    always_comb begin
        n_off   = head[4] - CH_ONE;
        valid_n = (head[4] >= CH_ONE) && (head[4] <= CH_EIGHT);
        n_idx   = n_off[2:0];
        bit_sel = 8'b1 << n_idx;

        dec.hit     = 1'b0;
        dec.led_new = led_cur;
        if (head[0] == CH_HASH) begin
            if (head[1] == CH_L && head[2] == CH_E && head[3] == CH_D) begin
                if (head[5] == CH_O && head[6] == CH_N) begin
                    if (valid_n) begin
                        dec.hit     = 1'b1;
                        dec.led_new = led_cur | bit_sel;
                    end
                end else if (head[5] == CH_O && head[6] == CH_F && head[7] == CH_F) begin
                    if (valid_n) begin
                        dec.hit     = 1'b1;
                        dec.led_new = led_cur & ~bit_sel;
                    end
                end
            end else if (head[1] == CH_C && head[2] == CH_M && head[3] == CH_D) begin
                if (head[4] == CH_ONE) begin
                    dec.hit     = 1'b1;
                    dec.led_new = 8'hff;
                end else if (head[4] == CH_TWO) begin
                    dec.hit     = 1'b1;
                    dec.led_new = 8'h00;
                end
            end
        end
    end

endmodule

// File: design/clcd_core.sv
// Line state: length count, CR flag, header store and LED register.
// Depends on clcd_pkg and clcd_decode.
module clcd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output clcd_pkg::result_t res
);
    import clcd_pkg::*;

    localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(LINE_MAX);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             cr_seen_reg, cr_seen_next;
    head_t            head_reg;
    logic [7:0]       led_reg, led_next;
    logic             head_wr;
    logic [CNT_W:0]   count_inc;
    decode_t          dec;

    clcd_decode u_decode (
        .head    (head_reg),
        .led_cur (led_reg),
        .dec     (dec)
    );

    always_comb begin
        count_inc        = {1'b0, count_reg} + 1'b1;
        count_next       = count_reg;
        cr_seen_next     = cr_seen_reg;
        led_next         = led_reg;
        head_wr          = 1'b0;
        res.line_event   = EV_TAKEN;
        res.command_hit  = 1'b0;
        if (cr_seen_reg) begin
            count_next   = '0;
            cr_seen_next = 1'b0;
            if (rx_byte != BYTE_LF) begin
                res.line_event = EV_DROP_LF;
            end else begin
                res.line_event  = EV_LINE;
                res.command_hit = dec.hit;
                led_next        = dec.led_new;
            end
        end else if (rx_byte == BYTE_CR) begin
            cr_seen_next = 1'b1;
        end else begin
            head_wr = (count_reg < CNT_W'(HEAD_DEPTH));
            if (count_inc >= LIMIT) begin
                count_next     = '0;
                res.line_event = EV_DROP_OVF;
            end else begin
                count_next = count_inc[CNT_W-1:0];
            end
        end
        res.led_mask = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cr_seen_reg <= 1'b0;
            led_reg     <= '0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= '0;
            end
        end else if (step) begin
            count_reg   <= count_next;
            cr_seen_reg <= cr_seen_next;
            led_reg     <= led_next;
            if (head_wr) begin
                head_reg[count_reg[HEAD_IDX_W-1:0]] <= rx_byte;
            end
        end
    end

endmodule

// File: design/crlf_line_led_command_decoder.sv
// Top level of the CR LF line LED command decoder: input and result registers.
// Depends on clcd_pkg and clcd_core.
//
// Usage
//   s_* : received bytes, one byte per word in s_tdata[7:0].
//   m_* : one result word per input byte. m_tuser[1:0] is the line event
//         (byte taken, line complete, dropped for missing LF, dropped on
//         overflow); m_tdata carries the LED mask and the command-hit flag.
//   Path: a byte accepted is held in the input register; its result is loaded
//   into the result register once that slot is free or emptying, then offered on m_*.
//   Throughput: one byte per cycle while m_tready is high; the line state,
//   header decode and LED update all settle in the single step from input
//   to result register.
//   Reset (aresetn low, synchronous): both registers empty, line count and
//   CR flag cleared, header store zeroed, all LEDs dark.
//   Stall: while m_tready is low a waiting result holds; the input register
//   still takes one more byte, after which s_tready drops until the result
//   is taken. No word is lost or repeated.
module crlf_line_led_command_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] led_mask, [8] command_hit, [15:9] zero
    output logic [1:0]  m_tuser     // [1:0] line_event
);
    import clcd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       advance;

    // Move the held byte forward when the result slot is free or emptying
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    clcd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.command_hit, out_reg.led_mask};
    assign m_tuser  = out_reg.line_event;

endmodule
